// ----- rtl/dcl_pkg.sv -----
// package: shared types, constants and codes for the dragon coherent cache
`timescale 1ns / 1ps
`default_nettype none
package dcl_pkg;

   localparam int NumSetsDefault   = 256;
   localparam int WaysDefault      = 4;
   localparam int LineBytesDefault = 64;
   localparam int AddrBitsDefault  = 32;
   localparam int AddrWidth        = 32;

   typedef enum logic [2:0] {
      OP_READ    = 3'd0,
      OP_WRITE   = 3'd1,
      OP_BUS_RD  = 3'd2,
      OP_BUS_UPD = 3'd3,
      OP_BUS_RDU = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      ST_E  = 2'd0,
      ST_SC = 2'd1,
      ST_SM = 2'd2,
      ST_M  = 2'd3
   } coh_state_type;

   typedef enum logic [1:0] {
      BUS_NONE  = 2'd0,
      BUS_RD    = 2'd1,
      BUS_RDUPD = 2'd2,
      BUS_UPD   = 2'd3
   } bus_req_type;

   typedef enum logic [1:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_LOOKUP,
      FSM_RESULT
   } fsm_state_type;

   typedef struct packed {
      logic       hit;
      logic [1:0] bus_request;
      logic       writeback;
      logic       intervention;
   } result_type;

endpackage
`default_nettype wire

// ----- rtl/dcl_if.sv -----
// interfaces: request and response channels
`timescale 1ns / 1ps
`default_nettype none
interface dcl_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [31:0] address;
   logic        no_sharers;
   modport source (output valid, opcode, address, no_sharers, input ready);
   modport sink   (input valid, opcode, address, no_sharers, output ready);
endinterface

interface dcl_rsp_if;
   logic       valid;
   logic       ready;
   logic       hit;
   logic [1:0] bus_request;
   logic       writeback;
   logic       intervention;
   modport source (output valid, hit, bus_request, writeback, intervention, input ready);
   modport sink   (input valid, hit, bus_request, writeback, intervention, output ready);
endinterface
`default_nettype wire

// ----- rtl/dcl_set_update.sv -----
// set update: hit search, victim choice, lru and dragon transitions for one set
`timescale 1ns / 1ps
`default_nettype none
module dcl_set_update #(
   parameter int WAYS     = 4,
   parameter int TAG_BITS = 18,
   parameter int RANK_W   = 2
) (
   input  wire logic [2:0]                 opcode,
   input  wire logic [TAG_BITS-1:0]        tag,
   input  wire logic                       no_sharers,
   input  wire logic                       coh_en,
   input  wire logic [WAYS-1:0][TAG_BITS-1:0] tags_rd,
   input  wire logic [WAYS-1:0]            valid_rd,
   input  wire logic [WAYS-1:0]            dirty_rd,
   input  wire logic [WAYS-1:0][1:0]       coh_rd,
   input  wire logic [WAYS-1:0][RANK_W-1:0] rank_rd,
   output logic [WAYS-1:0]                 valid_wr,
   output logic [WAYS-1:0]                 dirty_wr,
   output logic [WAYS-1:0][1:0]            coh_wr,
   output logic [WAYS-1:0][RANK_W-1:0]     rank_wr,
   output logic [WAYS-1:0]                 tag_we,
   output dcl_pkg::result_type             result
);
   import dcl_pkg::*;

   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam logic [RANK_W:0] RankMax = (RANK_W + 1)'(WAYS - 1);

   logic [WAYS-1:0] match;
   logic            hit_any, is_local, is_snoop, wr;
   logic [WAY_W-1:0] way, hway, vway, lru_way;
   logic            inv_found;
   logic [RANK_W:0] best_rank, old_rank;
   logic [1:0]      cs;
   logic            sel_valid;

   always_comb begin
      match   = '0;
      hit_any = 1'b0;
      hway    = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         match[w] = valid_rd[w] && (tags_rd[w] == tag);
         if (match[w]) begin
            hway = WAY_W'(w);
         end
      end
      hit_any = |match;
      inv_found = 1'b0;
      vway      = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (!valid_rd[w]) begin
            inv_found = 1'b1;
            vway      = WAY_W'(w);
         end
      end
      lru_way   = '0;
      best_rank = '0;
      for (int w = 0; w < WAYS; w++) begin
         if ({1'b0, rank_rd[w]} >= best_rank) begin
            lru_way   = WAY_W'(w);
            best_rank = {1'b0, rank_rd[w]};
         end
      end
   end

   always_comb begin
      is_local = (opcode == OP_READ) || (opcode == OP_WRITE);
      is_snoop = (opcode == OP_BUS_RD) || (opcode == OP_BUS_UPD) || (opcode == OP_BUS_RDU);
      wr       = (opcode == OP_WRITE);
      way      = hit_any ? hway : (inv_found ? vway : lru_way);
      sel_valid = valid_rd[way];
      cs       = coh_rd[way];
      old_rank = sel_valid ? {1'b0, rank_rd[way]} : (RANK_W + 1)'(WAYS);
      valid_wr = valid_rd;
      dirty_wr = dirty_rd;
      coh_wr   = coh_rd;
      rank_wr  = rank_rd;
      tag_we   = '0;
      result   = '0;
      if (is_local) begin
         result.hit = hit_any;
         for (int j = 0; j < WAYS; j++) begin
            if (WAY_W'(j) != way && valid_rd[j] && ({1'b0, rank_rd[j]} < old_rank)
                && ({1'b0, rank_rd[j]} < RankMax)) begin
               rank_wr[j] = rank_rd[j] + 1'b1;
            end
         end
         rank_wr[way] = '0;
         if (hit_any) begin
            if (wr) dirty_wr[way] = 1'b1;
            if (coh_en && wr) begin
               if (no_sharers) begin
                  coh_wr[way] = ST_M;
                  if (cs == ST_SC || cs == ST_SM) result.bus_request = BUS_UPD;
               end else begin
                  coh_wr[way] = ST_SM;
                  result.bus_request = BUS_UPD;
               end
            end
         end else begin
            result.writeback = sel_valid && dirty_rd[way] && (cs != ST_SC);
            tag_we[way]   = 1'b1;
            valid_wr[way] = 1'b1;
            dirty_wr[way] = wr;
            if (coh_en) begin
               if (no_sharers) begin
                  coh_wr[way] = wr ? ST_M : ST_E;
               end else if (wr) begin
                  coh_wr[way] = ST_SM;
                  result.bus_request = BUS_RDUPD;
               end else begin
                  coh_wr[way] = ST_SC;
                  result.bus_request = BUS_RD;
               end
            end
         end
      end else if (is_snoop && hit_any) begin
         result.hit = 1'b1;
         if (coh_en) begin
            unique case (opcode)
               OP_BUS_RD: begin
                  if (cs == ST_E) begin
                     coh_wr[way] = ST_SC;
                     result.intervention = 1'b1;
                  end else if (cs == ST_SM) begin
                     result.writeback = 1'b1;
                  end else if (cs == ST_M) begin
                     result.writeback    = 1'b1;
                     result.intervention = 1'b1;
                     coh_wr[way] = ST_SM;
                  end
               end
               OP_BUS_UPD: begin
                  if (cs == ST_SM || cs == ST_SC) coh_wr[way] = ST_SC;
               end
               default: begin
                  result.writeback    = (cs == ST_SM) || (cs == ST_M);
                  result.intervention = (cs == ST_M) || (cs == ST_E);
                  coh_wr[way] = ST_SC;
               end
            endcase
         end
      end
   end

endmodule
`default_nettype wire

// ----- rtl/dragon_coherent_lru_cache_unit.sv -----
// top level: dragon coherent set-associative cache controller with true lru
// Each request word is handled in a read step and a lookup step plus the response
// handshake: the accept reads the set row (tags, valid, dirty, coherence state and
// lru ranks of all ways) from the set memories into registers, the lookup state
// then computes the outcome and writes the row back while the response word is
// registered. The next request is taken only once the response is accepted and
// the unit is back in idle, so no new word is taken while one is in flight.
// After reset a clearing pass writes every set row, during which no request is
// taken.
`timescale 1ns / 1ps
`default_nettype none
module dragon_coherent_lru_cache_unit #(
   parameter int NUM_SETS   = dcl_pkg::NumSetsDefault,
   parameter int WAYS       = dcl_pkg::WaysDefault,
   parameter int LINE_BYTES = dcl_pkg::LineBytesDefault,
   parameter int ADDR_BITS  = dcl_pkg::AddrBitsDefault
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_write_enable,
   input  wire logic csr_write_data,
   dcl_req_if.sink   req,
   dcl_rsp_if.source rsp
);
   import dcl_pkg::*;

   localparam int OFF_BITS = $clog2(LINE_BYTES + 1) - 1;
   localparam int SET_BITS = $clog2(NUM_SETS + 1) - 1;
   localparam int IDX_W    = (SET_BITS > 0) ? SET_BITS : 1;
   localparam int EFF_ADDR = (ADDR_BITS < AddrWidth) ? ADDR_BITS : AddrWidth;
   localparam int TAG_RAW  = EFF_ADDR - OFF_BITS - SET_BITS;
   localparam int TAG_BITS = (TAG_RAW > 0) ? TAG_RAW : 1;
   localparam int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int DEPTH    = 1 << SET_BITS;

   logic [WAYS-1:0][TAG_BITS-1:0] tag_mem [DEPTH];
   logic [WAYS*(2+2+RANK_W)-1:0]  st_mem  [DEPTH];

   fsm_state_type state_ff, state_in;
   logic          coh_en_ff;
   logic [IDX_W:0] clr_ff, clr_in;
   logic [2:0]    op_ff;
   logic [IDX_W-1:0] set_ff;
   logic [TAG_BITS-1:0] tag_ff;
   logic          ns_ff;
   result_type    res_ff;
   logic [WAYS-1:0][TAG_BITS-1:0] tags_rd_ff;
   logic [WAYS*(2+2+RANK_W)-1:0]  st_rd_ff;

   logic [IDX_W-1:0] req_set;
   logic [TAG_BITS-1:0] req_tag;
   logic [EFF_ADDR-1:0] addr_m;

   logic [WAYS-1:0] valid_rd, dirty_rd, valid_wr, dirty_wr, tag_we;
   logic [WAYS-1:0][1:0] coh_rd, coh_wr;
   logic [WAYS-1:0][RANK_W-1:0] rank_rd, rank_wr;
   logic [WAYS*(2+2+RANK_W)-1:0] st_wr;
   result_type    res_comb;
   logic          st_we;
   logic [IDX_W-1:0] st_addr;

   always_comb begin
      addr_m  = req.address[EFF_ADDR-1:0];
      req_set = (SET_BITS > 0) ? IDX_W'(addr_m >> OFF_BITS) : '0;
      req_tag = (TAG_RAW > 0) ? TAG_BITS'(addr_m >> (OFF_BITS + SET_BITS)) : '0;
   end

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         valid_rd[w] = st_rd_ff[w*(4+RANK_W)];
         dirty_rd[w] = st_rd_ff[w*(4+RANK_W)+1];
         coh_rd[w]   = st_rd_ff[w*(4+RANK_W)+2 +: 2];
         rank_rd[w]  = st_rd_ff[w*(4+RANK_W)+4 +: RANK_W];
         st_wr[w*(4+RANK_W)]             = valid_wr[w];
         st_wr[w*(4+RANK_W)+1]           = dirty_wr[w];
         st_wr[w*(4+RANK_W)+2 +: 2]      = coh_wr[w];
         st_wr[w*(4+RANK_W)+4 +: RANK_W] = rank_wr[w];
      end
   end

   dcl_set_update #(.WAYS(WAYS), .TAG_BITS(TAG_BITS), .RANK_W(RANK_W)) u_upd (
      .opcode(op_ff), .tag(tag_ff), .no_sharers(ns_ff), .coh_en(coh_en_ff),
      .tags_rd(tags_rd_ff), .valid_rd(valid_rd), .dirty_rd(dirty_rd),
      .coh_rd(coh_rd), .rank_rd(rank_rd), .valid_wr(valid_wr), .dirty_wr(dirty_wr),
      .coh_wr(coh_wr), .rank_wr(rank_wr), .tag_we(tag_we), .result(res_comb)
   );

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         FSM_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (IDX_W + 1)'(DEPTH - 1)) state_in = FSM_IDLE;
         end
         FSM_IDLE:   if (req.valid) state_in = FSM_LOOKUP;
         FSM_LOOKUP: state_in = FSM_RESULT;
         FSM_RESULT: if (rsp.ready) state_in = FSM_IDLE;
         default:    state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      req.ready = (state_ff == FSM_IDLE);
      rsp.valid = (state_ff == FSM_RESULT);
      st_we     = (state_ff == FSM_CLEAR) || (state_ff == FSM_LOOKUP);
      st_addr   = (state_ff == FSM_CLEAR) ? clr_ff[IDX_W-1:0] : set_ff;
      rsp.hit          = res_ff.hit;
      rsp.bus_request  = res_ff.bus_request;
      rsp.writeback    = res_ff.writeback;
      rsp.intervention = res_ff.intervention;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FSM_CLEAR;
         clr_ff    <= '0;
         coh_en_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (csr_write_enable) coh_en_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         op_ff  <= req.opcode;
         set_ff <= req_set;
         tag_ff <= req_tag;
         ns_ff  <= req.no_sharers;
      end
      if (state_ff == FSM_LOOKUP) res_ff <= res_comb;
   end

   // set row memories: read on accept, write back in lookup cycle
   always_ff @(posedge clock) begin
      if (st_we) st_mem[st_addr] <= (state_ff == FSM_CLEAR) ? '0 : st_wr;
      if (req.valid && req.ready) st_rd_ff <= st_mem[req_set];
   end

   always_ff @(posedge clock) begin
      for (int w = 0; w < WAYS; w++) begin
         if (state_ff == FSM_LOOKUP && tag_we[w]) tag_mem[set_ff][w] <= tag_ff;
      end
      if (req.valid && req.ready) tags_rd_ff <= tag_mem[req_set];
   end

   a_one_phase: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("request and response overlap");
   a_rsp_after_lookup: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(state_ff) == FSM_LOOKUP)
      else $error("response without lookup");
   a_snoop_no_bus: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_LOOKUP && op_ff != OP_READ && op_ff != OP_WRITE)
      |=> res_ff.bus_request == BUS_NONE) else $error("snoop issued bus request");

endmodule
`default_nettype wire

// ----- verif/tb_dragon_coherent_lru_cache_unit.sv -----
// testbench: dragon coherent lru cache unit, directed table then random words vs predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_dragon_coherent_lru_cache_unit;
   import dcl_pkg::*;

   localparam int NSET = 256;
   localparam int NWAY = 4;
   localparam int IdleLimit = 20000;

   typedef struct {
      logic [2:0]  op;
      logic [31:0] addr;
      logic        alone;
      bit          typed;
      result_type  res;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;

   dcl_req_if req ();
   dcl_rsp_if rsp ();

   dragon_coherent_lru_cache_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req),
      .rsp              (rsp)
   );

   // mirrored cache state
   logic [17:0]   line_tag   [NSET*NWAY];
   bit            line_valid [NSET*NWAY];
   bit            line_dirty [NSET*NWAY];
   coh_state_type line_state [NSET*NWAY];
   int            line_rank  [NSET*NWAY];
   bit            coh_on;

   result_type pending_results[$];
   bit         next_is_typed;
   result_type next_typed_res;
   int         mismatches;
   int         idle_cycles;
   int         hold_left;
   bit         calm;
   logic [17:0] tag_pool [6];
   int          set_pool [3];

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic touch_way(input int s, input int w, input bit was_valid);
      int old;
      int j;
      old = was_valid ? line_rank[s*NWAY+w] : NWAY;
      for (j = 0; j < NWAY; j++) begin
         if (j != w && line_valid[s*NWAY+j] && line_rank[s*NWAY+j] < old &&
             line_rank[s*NWAY+j] < NWAY-1)
            line_rank[s*NWAY+j]++;
      end
      line_rank[s*NWAY+w] = 0;
   endtask

   task automatic predict_access(input logic [2:0] op, input logic [31:0] a,
                                 input logic alone, output result_type r);
      int s;
      int w;
      int way;
      int e;
      bit was_valid;
      bit wr;
      logic [17:0] t;
      coh_state_type cs;
      s = int'(a[13:6]);
      t = a[31:14];
      way = NWAY;
      r = '0;
      for (w = NWAY-1; w >= 0; w--)
         if (line_valid[s*NWAY+w] && line_tag[s*NWAY+w] == t) way = w;
      wr = (op == OP_WRITE);
      if (op == OP_READ || op == OP_WRITE) begin
         if (way < NWAY) begin
            r.hit = 1'b1;
            e = s*NWAY + way;
            touch_way(s, way, 1'b1);
            if (wr) line_dirty[e] = 1'b1;
            if (coh_on && wr) begin
               cs = line_state[e];
               if (alone) begin
                  line_state[e] = ST_M;
                  if (cs == ST_SC || cs == ST_SM) r.bus_request = BUS_UPD;
               end else begin
                  line_state[e] = ST_SM;
                  r.bus_request = BUS_UPD;
               end
            end
         end else begin
            way = -1;
            for (w = NWAY-1; w >= 0; w--)
               if (!line_valid[s*NWAY+w]) way = w;
            if (way < 0) begin
               way = 0;
               for (w = 0; w < NWAY; w++)
                  if (line_rank[s*NWAY+w] >= line_rank[s*NWAY+way]) way = w;
            end
            e = s*NWAY + way;
            was_valid = line_valid[e];
            if (was_valid && line_dirty[e] && line_state[e] != ST_SC) r.writeback = 1'b1;
            touch_way(s, way, was_valid);
            line_tag[e] = t;
            line_valid[e] = 1'b1;
            line_dirty[e] = wr;
            if (coh_on) begin
               if (alone) line_state[e] = wr ? ST_M : ST_E;
               else if (wr) begin
                  line_state[e] = ST_SM;
                  r.bus_request = BUS_RDUPD;
               end else begin
                  line_state[e] = ST_SC;
                  r.bus_request = BUS_RD;
               end
            end
         end
      end else if ((op == OP_BUS_RD || op == OP_BUS_UPD || op == OP_BUS_RDU) && way < NWAY) begin
         r.hit = 1'b1;
         e = s*NWAY + way;
         if (coh_on) begin
            cs = line_state[e];
            if (op == OP_BUS_RD) begin
               if (cs == ST_E) begin
                  line_state[e] = ST_SC;
                  r.intervention = 1'b1;
               end else if (cs == ST_SM) r.writeback = 1'b1;
               else if (cs == ST_M) begin
                  r.writeback = 1'b1;
                  r.intervention = 1'b1;
                  line_state[e] = ST_SM;
               end
            end else if (op == OP_BUS_UPD) begin
               if (cs == ST_SM || cs == ST_SC) line_state[e] = ST_SC;
            end else begin
               if (cs == ST_SM) r.writeback = 1'b1;
               else if (cs == ST_M) begin
                  r.writeback = 1'b1;
                  r.intervention = 1'b1;
               end else if (cs == ST_E) r.intervention = 1'b1;
               line_state[e] = ST_SC;
            end
         end
      end
   endtask

   // check responses first, then predict the accepted request word
   always @(posedge clock) begin
      result_type got;
      result_type want;
      result_type pred;
      if (!reset) begin
         if ((rsp.valid && rsp.ready) || (req.valid && req.ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.hit, rsp.bus_request, rsp.writeback, rsp.intervention};
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response word %b", got);
            end else begin
               want = pending_results.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected hit %b bus %0d wb %b itv %b, got %b %0d %b %b",
                              want.hit, want.bus_request, want.writeback, want.intervention,
                              got.hit, got.bus_request, got.writeback, got.intervention);
               end
            end
         end
         if (req.valid && req.ready) begin
            predict_access(req.opcode, req.address, req.no_sharers, pred);
            pending_results.push_back(next_is_typed ? next_typed_res : pred);
         end
      end
   end

   initial begin
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (idle_cycles >= IdleLimit) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp.ready = 1'b0;
            hold_left--;
         end else rsp.ready = calm || ($urandom_range(99) >= 31);
      end
   end

   task automatic send_word(input logic [2:0] op, input logic [31:0] a, input logic alone,
                            input bit typed, input result_type res);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 31) begin
         req.valid = 1'b0;
         @(negedge clock);
      end
      req.valid = 1'b1;
      req.opcode = op;
      req.address = a;
      req.no_sharers = alone;
      next_is_typed = typed;
      next_typed_res = res;
      do @(posedge clock); while (!(req.valid && req.ready));
      @(negedge clock);
      req.valid = 1'b0;
   endtask

   task automatic drain_and_set(input bit enable);
      wait (pending_results.size() == 0);
      repeat (6) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data = enable;
      coh_on = enable;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic random_words(input int count);
      int k;
      int pick;
      logic [2:0] op;
      logic [31:0] a;
      for (k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         if (pick < 70) op = 3'($urandom_range(1));
         else if (pick < 95) op = 3'($urandom_range(4, 2));
         else op = 3'($urandom_range(7, 5));
         if ($urandom_range(99) < 85)
            a = {tag_pool[$urandom_range(5)], set_pool[$urandom_range(2)][7:0],
                 6'($urandom)};
         else a = $urandom;
         send_word(op, a, 1'($urandom_range(1)), 1'b0, '0);
      end
   endtask

   stim_row_type rows[] = '{
      '{OP_READ,    32'h0000_0000, 1'b1, 1'b1, '{1'b0, BUS_NONE, 1'b0, 1'b0}},
      '{OP_WRITE,   32'h0000_0004, 1'b1, 1'b1, '{1'b1, BUS_NONE, 1'b0, 1'b0}},
      '{OP_BUS_RD,  32'h0000_0000, 1'b0, 1'b1, '{1'b1, BUS_NONE, 1'b1, 1'b1}},
      '{OP_WRITE,   32'h0000_003f, 1'b0, 1'b1, '{1'b1, BUS_UPD,  1'b0, 1'b0}},
      '{OP_BUS_UPD, 32'h0000_0000, 1'b0, 1'b1, '{1'b1, BUS_NONE, 1'b0, 1'b0}},
      '{OP_BUS_RDU, 32'h0000_0000, 1'b0, 1'b1, '{1'b1, BUS_NONE, 1'b0, 1'b0}},
      '{OP_READ,    32'h0000_4000, 1'b0, 1'b1, '{1'b0, BUS_RD,    1'b0, 1'b0}},
      '{OP_WRITE,   32'h0000_8000, 1'b0, 1'b1, '{1'b0, BUS_RDUPD, 1'b0, 1'b0}},
      '{OP_WRITE,   32'h0000_c000, 1'b1, 1'b0, '0},
      // set full: lru victim is the dirty shared-clean line, no writeback
      '{OP_WRITE,   32'h0001_0000, 1'b1, 1'b0, '0},
      '{OP_READ,    32'h0000_c010, 1'b0, 1'b0, '0},
      '{OP_BUS_RD,  32'h0000_8000, 1'b1, 1'b0, '0},
      '{OP_BUS_RDU, 32'h0001_0000, 1'b1, 1'b0, '0},
      '{OP_READ,    32'h0001_4000, 1'b1, 1'b0, '0},
      '{OP_WRITE,   32'h0001_8000, 1'b0, 1'b0, '0},
      '{OP_READ,    32'hffff_ffff, 1'b1, 1'b1, '{1'b0, BUS_NONE, 1'b0, 1'b0}},
      '{OP_WRITE,   32'hffff_ffc0, 1'b1, 1'b0, '0},
      '{OP_BUS_RD,  32'hffff_ffff, 1'b0, 1'b0, '0},
      '{OP_BUS_UPD, 32'h1234_5678, 1'b1, 1'b1, '{1'b0, BUS_NONE, 1'b0, 1'b0}},
      '{3'd5,       32'h0000_0000, 1'b1, 1'b1, '{1'b0, BUS_NONE, 1'b0, 1'b0}},
      '{3'd6,       32'hffff_ffff, 1'b0, 1'b1, '{1'b0, BUS_NONE, 1'b0, 1'b0}},
      '{3'd7,       32'h0000_4000, 1'b1, 1'b1, '{1'b0, BUS_NONE, 1'b0, 1'b0}}
   };

   initial begin
      int i;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = 1'b0;
      req.valid = 1'b0;
      req.opcode = OP_READ;
      req.address = '0;
      req.no_sharers = 1'b0;
      mismatches = 0;
      idle_cycles = 0;
      hold_left = 0;
      calm = 1'b0;
      next_is_typed = 1'b0;
      next_typed_res = '0;
      coh_on = 1'b1;
      for (i = 0; i < NSET*NWAY; i++) begin
         line_tag[i] = '0;
         line_valid[i] = 1'b0;
         line_dirty[i] = 1'b0;
         line_state[i] = ST_E;
         line_rank[i] = 0;
      end
      tag_pool = '{18'h0, 18'h3ffff, 18'h1, 18'h2aaaa, 18'h15555, 18'h2};
      set_pool = '{0, 255, 17};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      drain_and_set(1'b1);
      foreach (rows[i]) send_word(rows[i].op, rows[i].addr, rows[i].alone,
                                  rows[i].typed, rows[i].res);

      random_words(200);
      // long stretch with no idling on either side
      calm = 1'b1;
      random_words(60);
      calm = 1'b0;
      // receiver holds off while the sender keeps offering words
      hold_left = 150;
      random_words(20);
      // sender waits for every outstanding response
      wait (pending_results.size() == 0);
      random_words(60);

      drain_and_set(1'b0);
      random_words(180);
      drain_and_set(1'b1);
      random_words(180);

      wait (pending_results.size() == 0);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
`default_nettype wire

// ----- files.f -----
rtl/dcl_pkg.sv
rtl/dcl_if.sv
rtl/dcl_set_update.sv
rtl/dragon_coherent_lru_cache_unit.sv
verif/tb_dragon_coherent_lru_cache_unit.sv
